FILE: design/ovs_pkg.sv
// ----------------------------------------------------------------------------
// ovs_pkg
// shared types, constants and tables of the obstacle velocity shaper
// ----------------------------------------------------------------------------
`default_nettype none

package ovs_pkg;

    // behavior constants
    localparam int unsigned TIMEOUT_TICKS = 10;
    localparam bit          HOLONOMIC     = 1'b0;
    localparam logic [12:0] MIN_SPEED     = 13'd205;
    localparam logic [12:0] MIN_TURN      = 13'd205;
    localparam logic signed [15:0] MIN_TURN_S = signed'(16'(MIN_TURN));

    localparam logic signed [15:0] PI_Q12      = 16'sd12868;
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
    localparam logic [15:0]        MIN_SPAN    = 16'd4;
    localparam logic [12:0]        PROX_MAX    = 13'd4096;
    localparam int unsigned        CORDIC_X0   = 39797;
    localparam logic [7:0]         AGE_MAX     = 8'd255;
    localparam logic [7:0]         AGE_LIMIT   = 8'(TIMEOUT_TICKS);

    // datapath widths
    localparam int unsigned VW  = 36;   // working velocity
    localparam int unsigned CW  = 19;   // cordic x/y
    localparam int unsigned ZW  = 22;   // cordic angle accumulator
    localparam int unsigned MAW = 33;   // multiplier operand a
    localparam int unsigned MBW = 19;   // multiplier operand b
    localparam int unsigned PW  = MAW + MBW;
    localparam int unsigned DW  = 34;   // divider dividend / quotient
    localparam int unsigned DVW = 16;   // divider divisor
    localparam int unsigned SW  = 32;   // square root work

    typedef enum logic [2:0] {
        REG_SAFE_DISTANCE   = 3'd0,
        REG_DANGER_DISTANCE = 3'd1,
        REG_GAIN_LINEAR     = 3'd2,
        REG_GAIN_ANGULAR    = 3'd3,
        REG_MAX_SPEED_X     = 3'd4,
        REG_MAX_SPEED_Y     = 3'd5,
        REG_MAX_SPEED_NORM  = 3'd6,
        REG_MAX_TURN_RATE   = 3'd7
    } ovs_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ROT, ST_MODE,
        ST_AV0, ST_AV1, ST_AV2, ST_AVD, ST_AWD,
        ST_RT0, ST_RT1, ST_RT2,
        ST_HP0, ST_HPD, ST_HP1, ST_HP2, ST_HP3, ST_HP4,
        ST_LIM, ST_N0, ST_N1, ST_N2, ST_N3, ST_SQ,
        ST_NX0, ST_NX1, ST_NXD, ST_NY0, ST_NY1, ST_NYD,
        ST_DONE
    } ovs_state_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quotient;
        logic          rem_nz;
    } ovs_div_res_t;

    // arctan(2^-i) in Q.16
    function automatic logic [15:0] ovs_atan(input logic [3:0] idx);
        logic [15:0] r;
        case (idx)
            4'd0:    r = 16'd51472;
            4'd1:    r = 16'd30386;
            4'd2:    r = 16'd16055;
            4'd3:    r = 16'd8150;
            4'd4:    r = 16'd4091;
            4'd5:    r = 16'd2047;
            4'd6:    r = 16'd1024;
            4'd7:    r = 16'd512;
            4'd8:    r = 16'd256;
            4'd9:    r = 16'd128;
            4'd10:   r = 16'd64;
            4'd11:   r = 16'd32;
            4'd12:   r = 16'd16;
            4'd13:   r = 16'd8;
            4'd14:   r = 16'd4;
            default: r = 16'd2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ovs_in_if.sv
// ----------------------------------------------------------------------------
// ovs_in_if
// request channel: commanded velocity and optional obstacle report
// ----------------------------------------------------------------------------
`default_nettype none

interface ovs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    logic               obstacle_new;
    logic [15:0]        obstacle_range;
    logic signed [14:0] obstacle_bearing;

    modport source (output valid, cmd_vx, cmd_vy, cmd_wz, obstacle_new,
                    obstacle_range, obstacle_bearing, input ready);
    modport sink   (input valid, cmd_vx, cmd_vy, cmd_wz, obstacle_new,
                    obstacle_range, obstacle_bearing, output ready);
endinterface

`default_nettype wire

FILE: design/ovs_out_if.sv
// ----------------------------------------------------------------------------
// ovs_out_if
// result channel: shaped velocity and avoidance flag
// ----------------------------------------------------------------------------
`default_nettype none

interface ovs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_vx;
    logic signed [15:0] out_vy;
    logic signed [15:0] out_wz;
    logic               avoid_active;

    modport source (output valid, out_vx, out_vy, out_wz, avoid_active, input ready);
    modport sink   (input valid, out_vx, out_vy, out_wz, avoid_active, output ready);
endinterface

`default_nettype wire

FILE: design/ovs_div.sv
// ----------------------------------------------------------------------------
// ovs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_div
    import ovs_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [DW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output ovs_div_res_t        res
);

    localparam int unsigned CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DVW-1:0]  dvs_reg, dvs_next;
    logic [DVW:0]    rem_sh;
    logic [DVW:0]    rem_sub;
    logic            fits;

    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next = fits ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;
    assign res.rem_nz   = |rem_reg;

endmodule

`default_nettype wire

FILE: design/obstacle_velocity_shaper.sv
// ----------------------------------------------------------------------------
// obstacle_velocity_shaper
// bends a commanded planar velocity away from the last reported obstacle
// ----------------------------------------------------------------------------
// One request is worked at a time by a small sequencer around one shared
// multiplier, one bit-serial divider and one shift-add unit that runs the
// 16-step cordic and the square root. The longest path is differential
// avoidance plus norm limiting, with four divides. The result sits in an
// output register, so the next request is taken while an earlier result
// waits.
`default_nettype none

module obstacle_velocity_shaper
    import ovs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ovs_in_if.sink           cmd_in,
    ovs_out_if.source        res_out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    ovs_state_t state_reg, state_next;

    // configuration registers
    logic [15:0] safe_reg, danger_reg;
    logic [14:0] kv_reg, kw_reg, msx_reg, msy_reg, msn_reg, mtr_reg;

    // held obstacle state
    logic [15:0]        held_range_reg, held_range_next;
    logic signed [15:0] held_bearing_reg, held_bearing_next;
    logic               held_valid_reg, held_valid_next;
    logic [7:0]         report_age_reg, report_age_next;

    // request copy and working values
    logic signed [15:0]   cx_reg, cx_next, cy_reg, cy_next, cw_reg, cw_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 neg_reg, neg_next;
    logic [3:0]           it_reg, it_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [SW-1:0]        acc_reg, acc_next, sq_v_reg, sq_v_next, sq_r_reg, sq_r_next;
    logic signed [VW-1:0] vx_reg, vx_next, vy_reg, vy_next, wz_reg, wz_next;
    logic [15:0]          aux_reg, aux_next;
    logic                 sign_reg, sign_next;
    logic                 active_reg, active_next;

    // result register
    logic               ov_reg, ov_next;
    logic signed [15:0] ovx_reg, ovx_next, ovy_reg, ovy_next, owz_reg, owz_next;
    logic               oact_reg, oact_next;

    // shared units
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic                  prod_en;
    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [DVW-1:0]        div_divisor;
    ovs_div_res_t          div_res;

    logic accept;
    logic out_free;

    // derived terms
    logic signed [CW-1:0]  c_val, s_val;
    logic signed [16:0]    ks;
    logic signed [VW-1:0]  qe, fq;
    logic signed [PW-1:0]  prod_sh16, prod_sh4;
    logic [16:0]           span_raw;
    logic [15:0]           span;
    logic signed [15:0]    bear_in, bear_remap, bear_src, bear_fold;
    logic                  bear_neg;
    logic signed [CW-1:0]  rot_dx, rot_dy;
    logic signed [ZW-1:0]  rot_at;
    logic [SW-1:0]         sq_bit, sq_try;
    logic signed [VW-1:0]  av_vx;
    logic signed [VW-1:0]  av_mag_vx, av_mag_cx;

    ovs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // clamp to +-lim, then zero values inside the dead zone
    function automatic logic signed [VW-1:0] lim_axis(
        input logic signed [VW-1:0] v,
        input logic [14:0]          lim,
        input logic [12:0]          dead
    );
        logic signed [VW-1:0] l, r, a;
        l = signed'(VW'(lim));
        if (v > l)
            r = l;
        else if (v < -l)
            r = -l;
        else
            r = v;
        a = (r < 0) ? -r : r;
        if (a < signed'(VW'(dead)))
            r = '0;
        return r;
    endfunction

    function automatic logic [DW-1:0] mag_dw(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] m;
        m = (v < 0) ? -v : v;
        return m[DW-1:0];
    endfunction

    assign accept   = cmd_in.valid && cmd_in.ready;
    assign out_free = !ov_reg || res_out.ready;

    // cos/sin sign restored after the fold into the right half plane
    assign c_val = neg_reg ? -x_reg : x_reg;
    assign s_val = neg_reg ? -y_reg : y_reg;
    assign ks    = (held_bearing_reg < 0) ? -signed'(17'(kw_reg)) : signed'(17'(kw_reg));

    // floor quotient from the unsigned divider
    assign qe = signed'(VW'(div_res.quotient));
    assign fq = sign_reg ? -(qe + signed'(VW'(div_res.rem_nz))) : qe;

    assign prod_sh16 = prod_reg >>> 16;
    assign prod_sh4  = prod_reg >>> 4;

    assign span_raw = {1'b0, safe_reg} - {1'b0, danger_reg};
    assign span     = (span_raw[16] || span_raw[15:0] < MIN_SPAN) ? MIN_SPAN : span_raw[15:0];

    // bearing remap: zero points backwards
    assign bear_in    = 16'(cmd_in.obstacle_bearing);
    assign bear_remap = (bear_in > 0) ? (PI_Q12 - bear_in) : (-bear_in - PI_Q12);
    assign bear_src   = cmd_in.obstacle_new ? bear_remap : held_bearing_reg;
    always_comb
    begin
        bear_neg  = 1'b0;
        bear_fold = bear_src;
        if (bear_src > HALF_PI_Q12)
        begin
            bear_fold = bear_src - PI_Q12;
            bear_neg  = 1'b1;
        end
        else if (bear_src < -HALF_PI_Q12)
        begin
            bear_fold = bear_src + PI_Q12;
            bear_neg  = 1'b1;
        end
    end

    // one cordic rotation step
    assign rot_dx = y_reg >>> it_reg;
    assign rot_dy = x_reg >>> it_reg;
    assign rot_at = signed'(ZW'(ovs_atan(it_reg)));

    // one square root digit
    assign sq_bit = SW'(32'h4000_0000) >> {it_reg, 1'b0};
    assign sq_try = sq_r_reg + sq_bit;

    // differential avoidance of the forward axis, never speeding up
    assign av_vx     = signed'(VW'(cx_reg)) - fq;
    assign av_mag_vx = (av_vx < 0) ? -av_vx : av_vx;
    assign av_mag_cx = (cx_reg < 0) ? -signed'(VW'(cx_reg)) : signed'(VW'(cx_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_ROT;
            ST_ROT:
                if (it_reg == 4'd15)
                    state_next = ST_MODE;
            ST_MODE:
            begin
                state_next = ST_LIM;
                if (HOLONOMIC)
                begin
                    if (held_valid_reg && held_range_reg < safe_reg)
                        state_next = (held_range_reg <= danger_reg) ? ST_RT0 : ST_HP0;
                end
                else if (held_valid_reg)
                begin
                    if (held_range_reg < safe_reg && held_range_reg > danger_reg)
                        state_next = ST_AV0;
                    else if (held_range_reg <= danger_reg)
                        state_next = ST_RT0;
                end
            end
            ST_AV0: state_next = ST_AV1;
            ST_AV1: state_next = ST_AV2;
            ST_AV2: state_next = ST_AVD;
            ST_AVD:
                if (div_res.done)
                    state_next = ST_AWD;
            ST_AWD:
                if (div_res.done)
                    state_next = ST_LIM;
            ST_RT0: state_next = ST_RT1;
            ST_RT1: state_next = ST_RT2;
            ST_RT2: state_next = ST_LIM;
            ST_HP0: state_next = ST_HPD;
            ST_HPD:
                if (div_res.done)
                    state_next = ST_HP1;
            ST_HP1: state_next = ST_HP2;
            ST_HP2: state_next = ST_HP3;
            ST_HP3: state_next = ST_HP4;
            ST_HP4: state_next = ST_LIM;
            ST_LIM: state_next = (msn_reg == '0) ? ST_DONE : ST_N0;
            ST_N0:  state_next = ST_N1;
            ST_N1:  state_next = ST_N2;
            ST_N2:  state_next = ST_N3;
            ST_N3:  state_next = (acc_reg > prod_reg[SW-1:0]) ? ST_SQ : ST_DONE;
            ST_SQ:
                if (it_reg == 4'd15)
                    state_next = ST_NX0;
            ST_NX0: state_next = ST_NX1;
            ST_NX1: state_next = ST_NXD;
            ST_NXD:
                if (div_res.done)
                    state_next = ST_NY0;
            ST_NY0: state_next = ST_NY1;
            ST_NY1: state_next = ST_NYD;
            ST_NYD:
                if (div_res.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // shared unit controls
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        prod_en      = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_AV0:
            begin
                prod_en = 1'b1;
                mul_a   = (cx_reg < 0) ? -MAW'(cx_reg) : MAW'(cx_reg);
                mul_b   = signed'(MBW'(kv_reg));
            end
            ST_AV1:
            begin
                prod_en = 1'b1;
                mul_a   = prod_reg[MAW-1:0];
                mul_b   = c_val;
            end
            ST_AV2:
            begin
                prod_en      = 1'b1;
                mul_a        = MAW'(ks);
                mul_b        = c_val;
                div_start    = 1'b1;
                div_dividend = mag_dw(prod_sh16);
                div_divisor  = held_range_reg;
            end
            ST_AVD:
            begin
                div_start    = div_res.done;
                div_dividend = mag_dw(prod_sh4);
                div_divisor  = held_range_reg;
            end
            ST_RT0:
            begin
                prod_en = 1'b1;
                mul_a   = signed'(MAW'(kv_reg));
                mul_b   = c_val;
            end
            ST_RT1:
            begin
                prod_en = 1'b1;
                mul_a   = HOLONOMIC ? signed'(MAW'(kv_reg)) : MAW'(ks);
                mul_b   = HOLONOMIC ? s_val : c_val;
            end
            ST_HP0:
            begin
                div_start    = 1'b1;
                div_dividend = DW'({safe_reg - held_range_reg, 12'b0});
                div_divisor  = span;
            end
            ST_HP1:
            begin
                prod_en = 1'b1;
                mul_a   = signed'(MAW'(kv_reg));
                mul_b   = signed'(MBW'(aux_reg));
            end
            ST_HP2:
            begin
                prod_en = 1'b1;
                mul_a   = signed'(MAW'(prod_reg[27:12]));
                mul_b   = c_val;
            end
            ST_HP3:
            begin
                prod_en = 1'b1;
                mul_a   = signed'(MAW'(aux_reg));
                mul_b   = s_val;
            end
            ST_N0:
            begin
                prod_en = 1'b1;
                mul_a   = MAW'(vx_reg);
                mul_b   = MBW'(vx_reg);
            end
            ST_N1:
            begin
                prod_en = 1'b1;
                mul_a   = MAW'(vy_reg);
                mul_b   = MBW'(vy_reg);
            end
            ST_N2:
            begin
                prod_en = 1'b1;
                mul_a   = signed'(MAW'(msn_reg));
                mul_b   = signed'(MBW'(msn_reg));
            end
            ST_NX0:
            begin
                prod_en = 1'b1;
                mul_a   = (vx_reg < 0) ? -MAW'(vx_reg) : MAW'(vx_reg);
                mul_b   = signed'(MBW'(msn_reg));
            end
            ST_NX1, ST_NY1:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(prod_reg[29:0]);
                div_divisor  = sq_r_reg[DVW-1:0];
            end
            ST_NY0:
            begin
                prod_en = 1'b1;
                mul_a   = (vy_reg < 0) ? -MAW'(vy_reg) : MAW'(vy_reg);
                mul_b   = signed'(MBW'(msn_reg));
            end
            default:
            begin
                prod_en = 1'b0;
            end
        endcase
    end

    assign prod_next = prod_en ? PW'(mul_a * mul_b) : prod_reg;

    // datapath
    always_comb
    begin
        held_range_next   = held_range_reg;
        held_bearing_next = held_bearing_reg;
        held_valid_next   = held_valid_reg;
        report_age_next   = report_age_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cw_next     = cw_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        neg_next    = neg_reg;
        it_next     = it_reg;
        acc_next    = acc_reg;
        sq_v_next   = sq_v_reg;
        sq_r_next   = sq_r_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        wz_next     = wz_reg;
        aux_next    = aux_reg;
        sign_next   = sign_reg;
        active_next = active_reg;
        ov_next     = ov_reg && !res_out.ready;
        ovx_next    = ovx_reg;
        ovy_next    = ovy_reg;
        owz_next    = owz_reg;
        oact_next   = oact_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    // report intake and aging
                    if (cmd_in.obstacle_new)
                    begin
                        held_range_next   = cmd_in.obstacle_range;
                        held_bearing_next = bear_remap;
                        held_valid_next   = 1'b1;
                        report_age_next   = '0;
                    end
                    else
                    begin
                        if (report_age_reg < AGE_MAX)
                            report_age_next = report_age_reg + 8'd1;
                        if (TIMEOUT_TICKS > 0 && report_age_next > AGE_LIMIT)
                            held_valid_next = 1'b0;
                    end
                    cx_next  = cmd_in.cmd_vx;
                    cy_next  = cmd_in.cmd_vy;
                    cw_next  = cmd_in.cmd_wz;
                    vx_next  = VW'(cmd_in.cmd_vx);
                    vy_next  = VW'(cmd_in.cmd_vy);
                    wz_next  = VW'(cmd_in.cmd_wz);
                    x_next   = CW'(CORDIC_X0);
                    y_next   = '0;
                    z_next   = ZW'(bear_fold) <<< 4;
                    neg_next = bear_neg;
                    it_next  = '0;
                end
            ST_ROT:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_next = x_reg - rot_dx;
                    y_next = y_reg + rot_dy;
                    z_next = z_reg - rot_at;
                end
                else
                begin
                    x_next = x_reg + rot_dx;
                    y_next = y_reg - rot_dy;
                    z_next = z_reg + rot_at;
                end
                it_next = it_reg + 4'd1;
            end
            ST_MODE:
                active_next = held_valid_reg && held_range_reg < safe_reg;
            ST_AV2:
                sign_next = prod_reg < 0;
            ST_AVD:
                if (div_res.done)
                begin
                    if (av_mag_vx > av_mag_cx &&
                        ((av_vx > 0 && cx_reg > 0) || (av_vx < 0 && cx_reg < 0)))
                        vx_next = VW'(cx_reg);
                    else
                        vx_next = av_vx;
                    sign_next = prod_reg < 0;
                end
            ST_AWD:
                if (div_res.done)
                    wz_next = signed'(VW'(cw_reg)) + fq;
            ST_RT1:
                vx_next = VW'((-prod_reg) >>> 16);
            ST_RT2:
                if (HOLONOMIC)
                begin
                    vy_next = VW'(prod_sh16);
                    wz_next = '0;
                end
                else
                    wz_next = VW'(prod_sh16);
            ST_HPD:
                if (div_res.done)
                    aux_next = (div_res.quotient > DW'(PROX_MAX)) ?
                               16'(PROX_MAX) : div_res.quotient[15:0];
            ST_HP2:
                aux_next = prod_reg[27:12];
            ST_HP3:
                vx_next = signed'(VW'(cx_reg)) - VW'(prod_sh16);
            ST_HP4:
                vy_next = signed'(VW'(cy_reg)) + VW'(prod_sh16);
            ST_LIM:
            begin
                vx_next = lim_axis(vx_reg, msx_reg, MIN_SPEED);
                vy_next = lim_axis(vy_reg, msy_reg, MIN_SPEED);
                wz_next = lim_axis(wz_reg, mtr_reg, MIN_TURN);
            end
            ST_N1:
                acc_next = prod_reg[SW-1:0];
            ST_N2:
                acc_next = acc_reg + prod_reg[SW-1:0];
            ST_N3:
            begin
                sq_v_next = acc_reg;
                sq_r_next = '0;
                it_next   = '0;
            end
            ST_SQ:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_next = sq_v_reg - sq_try;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit;
                end
                else
                    sq_r_next = sq_r_reg >> 1;
                it_next = it_reg + 4'd1;
            end
            ST_NXD:
                if (div_res.done)
                    vx_next = (vx_reg < 0) ? -qe : qe;
            ST_NYD:
                if (div_res.done)
                    vy_next = (vy_reg < 0) ? -qe : qe;
            ST_DONE:
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ovx_next  = vx_reg[15:0];
                    ovy_next  = vy_reg[15:0];
                    owz_next  = wz_reg[15:0];
                    oact_next = active_reg;
                end
            default:
            begin
                it_next = it_reg;
            end
        endcase
    end

    // control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_range_reg   <= '0;
            held_bearing_reg <= '0;
            held_valid_reg   <= 1'b0;
            report_age_reg   <= '0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_range_reg   <= held_range_next;
            held_bearing_reg <= held_bearing_next;
            held_valid_reg   <= held_valid_next;
            report_age_reg   <= report_age_next;
            ov_reg           <= ov_next;
        end
    end

    // configuration registers, values masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_reg   <= 16'd2048;
            danger_reg <= 16'd819;
            kv_reg     <= 15'd819;
            kw_reg     <= 15'd1229;
            msx_reg    <= 15'd6144;
            msy_reg    <= 15'd6144;
            msn_reg    <= 15'd6144;
            mtr_reg    <= 15'd6144;
        end
        else if (cfg_we)
        begin
            case (ovs_reg_t'(cfg_index))
                REG_SAFE_DISTANCE:   safe_reg   <= cfg_wdata;
                REG_DANGER_DISTANCE: danger_reg <= cfg_wdata;
                REG_GAIN_LINEAR:     kv_reg     <= cfg_wdata[14:0];
                REG_GAIN_ANGULAR:    kw_reg     <= cfg_wdata[14:0];
                REG_MAX_SPEED_X:     msx_reg    <= cfg_wdata[14:0];
                REG_MAX_SPEED_Y:     msy_reg    <= cfg_wdata[14:0];
                REG_MAX_SPEED_NORM:  msn_reg    <= cfg_wdata[14:0];
                REG_MAX_TURN_RATE:   mtr_reg    <= cfg_wdata[14:0];
                default:             mtr_reg    <= mtr_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cw_reg     <= cw_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        neg_reg    <= neg_next;
        it_reg     <= it_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        sq_v_reg   <= sq_v_next;
        sq_r_reg   <= sq_r_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        wz_reg     <= wz_next;
        aux_reg    <= aux_next;
        sign_reg   <= sign_next;
        active_reg <= active_next;
        ovx_reg    <= ovx_next;
        ovy_reg    <= ovy_next;
        owz_reg    <= owz_next;
        oact_reg   <= oact_next;
    end

    assign cmd_in.ready         = (state_reg == ST_IDLE);
    assign res_out.valid        = ov_reg;
    assign res_out.out_vx       = ovx_reg;
    assign res_out.out_vy       = ovy_reg;
    assign res_out.out_wz       = owz_reg;
    assign res_out.avoid_active = oact_reg;

endmodule

`default_nettype wire

FILE: design/ovs_checker.sv
// ----------------------------------------------------------------------------
// ovs_checker
// port-level checks of the obstacle velocity shaper
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_checker
    import ovs_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] out_vx,
    input wire logic signed [15:0] out_wz
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // a stalled result holds its x and yaw velocities
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_vx) && $stable(out_wz))
        else $error("stalled result changed");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // the yaw dead zone holds on every result
    a_turn_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_wz == 16'sd0 || out_wz >= MIN_TURN_S || out_wz <= -MIN_TURN_S))
        else $error("yaw rate inside the dead zone");

endmodule

bind obstacle_velocity_shaper ovs_checker u_ovs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_vx    (res_out.out_vx),
    .out_wz    (res_out.out_wz)
);

`default_nettype wire

FILE: dv/ovs_tb_if.sv
// ----------------------------------------------------------------------------
// ovs_tb_if
// testbench-side notes for the shaper channels
// ----------------------------------------------------------------------------
// the channel interfaces come from the design folder; this file only holds
// the expected result record that the testbench queues between driver and checker
`timescale 1ns / 100ps

package ovs_tb_pkg;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] wz;
        logic               active;
    } shaped_cmd_t;

endpackage

FILE: dv/obstacle_velocity_shaper_tb.sv
// ----------------------------------------------------------------------------
// obstacle_velocity_shaper_tb
// checks the shaper against an in-bench predictor of its velocity shaping
// ----------------------------------------------------------------------------
// directed ticks cover field extremes, the danger boundary, stale reports and
// the norm limit; random phases then run obstacle sequences under several
// register settings with random sender gaps and, in all but one phase, random receiver stalls
`timescale 1ns / 100ps

module obstacle_velocity_shaper_tb;
    import ovs_pkg::*;
    import ovs_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    ovs_in_if  cmd_ch ();
    ovs_out_if res_ch ();

    obstacle_velocity_shaper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd_ch),
        .res_out   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the registers
    longint safe_d, danger_d, kv_gain, kw_gain, lim_x, lim_y, lim_norm, lim_turn;
    // predictor copy of the held report
    longint held_d, held_b, age;
    bit     held_ok;

    shaped_cmd_t expected_q[$];
    int  errors;
    int  accepted;
    int  results_seen;
    int  idle_cycles;
    bit  rx_stall_en;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------
    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint absv(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // rotation cordic after folding into the right half plane
    task automatic bearing_cos_sin(input longint a, output longint c, output longint s);
        longint atan_tab[16];
        longint x, y, z, dx, dy;
        bit     flip;
        atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        flip = 1'b0;
        if (a > HALF_PI_Q12)
        begin
            a = a - PI_Q12;
            flip = 1'b1;
        end
        else if (a < -HALF_PI_Q12)
        begin
            a = a + PI_Q12;
            flip = 1'b1;
        end
        x = CORDIC_X0;
        y = 0;
        z = a * 16;
        for (int i = 0; i < 16; i++)
        begin
            dx = fdiv(y, longint'(1) << i);
            dy = fdiv(x, longint'(1) << i);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_dead(longint v, longint lim, longint dead);
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        if (absv(v) < dead)
            v = 0;
        return v;
    endfunction

    // one control tick of the shaper, updating the held report
    task automatic predict_shaped(input logic signed [15:0] cvx, input logic signed [15:0] cvy,
                                  input logic signed [15:0] cwz, input logic onew,
                                  input logic [15:0] orng, input logic signed [14:0] obrg,
                                  output shaped_cmd_t res);
        longint cx, cy, cw, vx, vy, wz, c, s, ks, span, prox, rep, m, s2, len;
        bit act;
        cx = cvx; cy = cvy; cw = cwz;
        vx = cx; vy = cy; wz = cw;
        if (onew)
        begin
            held_d = orng;
            held_b = (obrg > 0) ? (PI_Q12 - longint'(obrg)) : (-longint'(obrg) - PI_Q12);
            held_ok = 1'b1;
            age = 0;
        end
        else
        begin
            if (age < 255)
                age++;
            if (TIMEOUT_TICKS > 0 && age > TIMEOUT_TICKS)
                held_ok = 1'b0;
        end
        act = held_ok && (held_d < safe_d);
        bearing_cos_sin(held_b, c, s);
        if (HOLONOMIC)
        begin
            if (act)
            begin
                span = safe_d - danger_d;
                if (span < longint'(MIN_SPAN))
                    span = MIN_SPAN;
                prox = ((safe_d - held_d) * 4096) / span;
                if (prox > 4096)
                    prox = 4096;
                rep = (kv_gain * prox) >> 12;
                if (held_d <= danger_d)
                begin
                    vx = fdiv(-kv_gain * c, 65536);
                    vy = fdiv(kv_gain * s, 65536);
                    wz = 0;
                end
                else
                begin
                    vx = cx - fdiv(rep * c, 65536);
                    vy = cy + fdiv(rep * s, 65536);
                end
            end
        end
        else if (held_ok)
        begin
            ks = (held_b < 0) ? -kw_gain : kw_gain;
            if (held_d < safe_d && held_d > danger_d)
            begin
                vx = cx - fdiv(absv(cx) * kv_gain * c, 65536 * held_d);
                // forward speed may never grow
                if (absv(vx) > absv(cx) && ((vx > 0 && cx > 0) || (vx < 0 && cx < 0)))
                    vx = cx;
                wz = cw + fdiv(ks * c, 16 * held_d);
            end
            else if (held_d <= danger_d)
            begin
                vx = fdiv(-kv_gain * c, 65536);
                wz = fdiv(ks * c, 65536);
            end
        end
        vx = clamp_dead(vx, lim_x, MIN_SPEED);
        vy = clamp_dead(vy, lim_y, MIN_SPEED);
        if (lim_norm > 0)
        begin
            m = lim_norm;
            s2 = vx * vx + vy * vy;
            if (s2 > m * m)
            begin
                len = root_floor(s2);
                vx = (vx < 0) ? -(absv(vx) * m / len) : (absv(vx) * m / len);
                vy = (vy < 0) ? -(absv(vy) * m / len) : (absv(vy) * m / len);
            end
        end
        wz = clamp_dead(wz, lim_turn, MIN_TURN);
        res.vx = 16'(vx);
        res.vy = 16'(vy);
        res.wz = 16'(wz);
        res.active = act;
    endtask

    // ------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(input ovs_reg_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SAFE_DISTANCE:   safe_d   = value;
            REG_DANGER_DISTANCE: danger_d = value;
            REG_GAIN_LINEAR:     kv_gain  = value[14:0];
            REG_GAIN_ANGULAR:    kw_gain  = value[14:0];
            REG_MAX_SPEED_X:     lim_x    = value[14:0];
            REG_MAX_SPEED_Y:     lim_y    = value[14:0];
            REG_MAX_SPEED_NORM:  lim_norm = value[14:0];
            default:             lim_turn = value[14:0];
        endcase
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // settle before touching the registers
        repeat (250) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] sf, input logic [15:0] dg,
                                 input logic [15:0] kv, input logic [15:0] kw,
                                 input logic [15:0] mx, input logic [15:0] my,
                                 input logic [15:0] mn, input logic [15:0] mt);
        wait_drained();
        write_reg(REG_SAFE_DISTANCE, sf);
        write_reg(REG_DANGER_DISTANCE, dg);
        write_reg(REG_GAIN_LINEAR, kv);
        write_reg(REG_GAIN_ANGULAR, kw);
        write_reg(REG_MAX_SPEED_X, mx);
        write_reg(REG_MAX_SPEED_Y, my);
        write_reg(REG_MAX_SPEED_NORM, mn);
        write_reg(REG_MAX_TURN_RATE, mt);
    endtask

    // ------------------------------------------------------------------
    // request driver: one tick, held until accepted
    // ------------------------------------------------------------------
    task automatic send_tick(input logic signed [15:0] cvx, input logic signed [15:0] cvy,
                             input logic signed [15:0] cwz, input logic onew,
                             input logic [15:0] orng, input logic signed [14:0] obrg);
        shaped_cmd_t res;
        cmd_ch.valid            <= 1'b1;
        cmd_ch.cmd_vx           <= cvx;
        cmd_ch.cmd_vy           <= cvy;
        cmd_ch.cmd_wz           <= cwz;
        cmd_ch.obstacle_new     <= onew;
        cmd_ch.obstacle_range   <= orng;
        cmd_ch.obstacle_bearing <= obrg;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predict_shaped(cvx, cvy, cwz, onew, orng, obrg, res);
        expected_q.push_back(res);
        accepted++;
    endtask

    // bursts with random gaps; a gap of zero keeps valid high back to back
    int burst_left;
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic signed [14:0] rand_bearing();
        case ($urandom_range(0, 5))
            0:       return 15'sd12868;
            1:       return -15'sd12868;
            2:       return 15'sd0;
            default: return 15'($signed($urandom_range(0, 25736)) - 12868);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_cmd();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'(15'($urandom_range(0, 8000)));
            3:       return -16'(15'($urandom_range(0, 8000)));
            4:       return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (!rx_stall_en)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 9) < 6);
    end

    always @(posedge clk)
    begin
        shaped_cmd_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with no request waiting");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_ch.out_vx !== e.vx)
                begin
                    $error("out_vx expected %0d actual %0d", e.vx, res_ch.out_vx);
                    errors++;
                end
                if (res_ch.out_vy !== e.vy)
                begin
                    $error("out_vy expected %0d actual %0d", e.vy, res_ch.out_vy);
                    errors++;
                end
                if (res_ch.out_wz !== e.wz)
                begin
                    $error("out_wz expected %0d actual %0d", e.wz, res_ch.out_wz);
                    errors++;
                end
                if (res_ch.avoid_active !== e.active)
                begin
                    $error("avoid_active expected %0b actual %0b", e.active,
                           res_ch.avoid_active);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** obstacle_velocity_shaper: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // no obstacle: plain limiting, dead zone and command extremes
        send_tick(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 16'd0, 15'sd0);
        send_tick(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 16'd0, 15'sd0);
        send_tick(16'sd204, -16'sd204, 16'sd205, 1'b0, 16'd0, 15'sd0);
        // report far away, then inside avoidance, right and left bearings
        send_tick(16'sd4096, 16'sd0, 16'sd0, 1'b1, 16'hffff, 15'sd12868);
        send_tick(16'sd4096, 16'sd500, 16'sd100, 1'b1, 16'd1500, 15'sd3000);
        send_tick(-16'sd4096, 16'sd0, -16'sd300, 1'b1, 16'd1500, -15'sd3000);
        send_tick(16'sd3000, 16'sd0, 16'sd0, 1'b1, 16'd1500, 15'sd0);
        send_tick(16'sd3000, 16'sd0, 16'sd0, 1'b1, 16'd1500, -15'sd12868);
        // range exactly at danger counts as danger, then just above, then zero
        send_tick(16'sd3000, 16'sd300, 16'sd0, 1'b1, 16'd819, 15'sd6434);
        send_tick(16'sd3000, 16'sd300, 16'sd0, 1'b1, 16'd820, -15'sd6434);
        send_tick(16'sd3000, 16'sd300, 16'sd0, 1'b1, 16'd0, 15'sd1);
        // age the report out past the timeout
        for (int i = 0; i < 13; i++)
            send_tick(16'sd5000, 16'sd5000, 16'sd1000, 1'b0, 16'hffff, 15'sd0);
    endtask

    task automatic test_random_phase(input int count);
        int run;
        logic [15:0] rng;
        logic signed [14:0] brg;
        run = 0;
        for (int i = 0; i < count; i++)
        begin
            pace_sender();
            // mostly steady obstacle tracks with jittered reports
            if (run == 0)
            begin
                run = $urandom_range(2, 20);
                rng = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 3000));
                brg = rand_bearing();
            end
            run--;
            if ($urandom_range(0, 3) != 0)
            begin
                rng = 16'(int'(rng) + $signed($urandom_range(0, 100)) - 50);
                send_tick(rand_cmd(), rand_cmd(), rand_cmd(), 1'b1, rng, brg);
            end
            else
                send_tick(rand_cmd(), rand_cmd(), rand_cmd(), 1'b0,
                          16'($urandom()), rand_bearing());
        end
    endtask

    task automatic test_drain_pause();
        // sender holds off until every result is back
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        send_tick(16'sd2000, -16'sd2000, 16'sd500, 1'b1, 16'd1200, 15'sd100);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors = 0; accepted = 0; results_seen = 0; idle_cycles = 0;
        burst_left = 0; rx_stall_en = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_SAFE_DISTANCE; cfg_wdata = '0;
        cmd_ch.valid = 1'b0; cmd_ch.cmd_vx = '0; cmd_ch.cmd_vy = '0;
        cmd_ch.cmd_wz = '0; cmd_ch.obstacle_new = 1'b0;
        cmd_ch.obstacle_range = '0; cmd_ch.obstacle_bearing = '0;
        safe_d = 2048; danger_d = 819; kv_gain = 819; kw_gain = 1229;
        lim_x = 6144; lim_y = 6144; lim_norm = 6144; lim_turn = 6144;
        held_d = 0; held_b = 0; held_ok = 1'b0; age = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        rx_stall_en = 1'b1;
        test_random_phase(300);
        test_drain_pause();
        // all-ones extremes, wide open limits
        load_settings(16'hffff, 16'hffff, 16'h7fff, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        test_random_phase(250);
        // all zero: no avoidance zone and no norm limit
        load_settings(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        test_random_phase(150);
        // danger above safe, tight norm
        load_settings(16'd1000, 16'd2500, 16'd4096, 16'd2000,
                      16'd8000, 16'd3000, 16'd1000, 16'd2000);
        test_random_phase(300);
        rx_stall_en = 1'b0;
        // mid settings, receiver always ready
        load_settings(16'd3000, 16'd500, 16'd12000, 16'd9000,
                      16'd20000, 16'd20000, 16'd0, 16'd30000);
        test_random_phase(400);
        rx_stall_en = 1'b1;
        load_settings(16'd2048, 16'd819, 16'd819, 16'd1229,
                      16'd6144, 16'd6144, 16'd6144, 16'd6144);
        test_random_phase(400);

        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        $display("covered %0d ticks, %0d results, six register settings", accepted,
                 results_seen);
        $display("obstacle tracks, stale reports, danger boundary and norm limiting");
        if (errors == 0)
            $display("** obstacle_velocity_shaper: PASSED **");
        else
            $display("** obstacle_velocity_shaper: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
design/ovs_pkg.sv
design/ovs_in_if.sv
design/ovs_out_if.sv
design/ovs_div.sv
design/obstacle_velocity_shaper.sv
design/ovs_checker.sv
dv/ovs_tb_if.sv
dv/obstacle_velocity_shaper_tb.sv
